### hdl/lda_gibbs_topic_sampler_top_defines.svh
// Assertion macros for the topic sampler.
`ifndef LDA_GIBBS_TOPIC_SAMPLER_TOP_DEFINES_SVH
`define LDA_GIBBS_TOPIC_SAMPLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property, disabled during reset.
`define LGTS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sampler assertion failed");
// Checked property, also active during reset.
`define LGTS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sampler assertion failed");
`else
`define LGTS_ASSERT(label, clk, rst, prop)
`define LGTS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### hdl/lgts_pkg.sv
`timescale 1ns / 1ps
package lgts_pkg;

  localparam int MAX_TOPICS  = 64;
  localparam int WORD_DEPTH  = 4096;
  localparam int DOC_DEPTH   = 1024;
  localparam int COUNT_BITS  = 24;

  localparam int TOPIC_BITS  = $clog2(MAX_TOPICS);
  localparam int WORD_BITS   = $clog2(WORD_DEPTH);
  localparam int DOC_BITS    = $clog2(DOC_DEPTH);
  localparam int NT_BITS     = 7;
  localparam int PRIOR_BITS  = 24;
  localparam int TOTAL_BITS  = 32;
  localparam int DATA_BITS   = 32;
  localparam int FUNC_BITS   = 3;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;

  // weight datapath widths
  localparam int A_BITS      = COUNT_BITS + FRAC_BITS + 1;
  localparam int HALF_BITS   = (A_BITS + 1) / 2;
  localparam int PROD_BITS   = 2 * A_BITS;
  localparam int VB_BITS     = 2 * PRIOR_BITS;
  localparam int D_BITS      = TOTAL_BITS + FRAC_BITS + 1;
  localparam int WEIGHT_BITS = 42;
  localparam int TOP_BITS    = PROD_BITS - WEIGHT_BITS;
  localparam int CMP_BITS    = (TOP_BITS > D_BITS) ? TOP_BITS : D_BITS;
  localparam int WCNT_BITS   = $clog2(WEIGHT_BITS);
  localparam int CUM_BITS    = 48;
  localparam int U_BITS      = CUM_BITS + 1;
  localparam int PHI_BITS    = DATA_BITS + CUM_BITS - 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BETA  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NT    = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VOCAB = 2'd3;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_SAMPLE  = 3'd0,
    FUNC_LOAD_WT = 3'd1,
    FUNC_LOAD_DT = 3'd2,
    FUNC_LOAD_TT = 3'd3,
    FUNC_LOAD_DL = 3'd4,
    FUNC_READ_WT = 3'd5,
    FUNC_READ_DT = 3'd6,
    FUNC_READ_TT = 3'd7
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_DEC_WR, ST_W_RD, ST_W_LD, ST_W_RUN, ST_PICK1,
    ST_PICK2, ST_S_RD, ST_S_CMP, ST_INC_RD, ST_INC_WR, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    WU_IDLE, WU_MUL, WU_CHK, WU_DIV, WU_DONE
  } wu_state_t;

  // operands of one weight computation
  typedef struct packed {
    logic [A_BITS-1:0] a;
    logic [A_BITS-1:0] c;
    logic [D_BITS-1:0] d;
  } wu_req_t;

endpackage

### hdl/lgts_weight_unit.sv
`timescale 1ns / 1ps
// floor(a*c/d) saturated to WEIGHT_BITS: 4 partial products, then
// one restoring divide step per cycle.
module lgts_weight_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  lgts_pkg::wu_req_t             req,
  output logic                          done,
  output logic [lgts_pkg::WEIGHT_BITS-1:0] weight
);
  import lgts_pkg::*;

  wu_state_t state, state_next;

  logic [A_BITS-1:0]      a_r, c_r;
  logic [D_BITS-1:0]      d_r;
  logic [PROD_BITS-1:0]   acc;
  logic [D_BITS-1:0]      rem;
  logic [WCNT_BITS-1:0]   cnt;
  logic [HALF_BITS-1:0]   ai, ci;
  logic [2*HALF_BITS-1:0] prod;
  logic [PROD_BITS-1:0]   prod_sh;
  logic [TOP_BITS-1:0]    top;
  logic                   sat;
  logic [D_BITS:0]        trial;
  logic                   qbit;

  always_comb begin
    ai = cnt[1] ? HALF_BITS'(a_r >> HALF_BITS) : a_r[HALF_BITS-1:0];
    ci = cnt[0] ? HALF_BITS'(c_r >> HALF_BITS) : c_r[HALF_BITS-1:0];
    prod = ai * ci;
    case (cnt[1:0])
      2'd0:    prod_sh = PROD_BITS'(prod);
      2'd3:    prod_sh = PROD_BITS'(prod) << (2 * HALF_BITS);
      default: prod_sh = PROD_BITS'(prod) << HALF_BITS;
    endcase
    top   = acc[PROD_BITS-1:WEIGHT_BITS];
    sat   = CMP_BITS'(top) >= CMP_BITS'(d_r);
    trial = {rem, acc[WEIGHT_BITS-1]};
    qbit  = trial >= {1'b0, d_r};
  end

  always_comb begin
    state_next = state;
    case (state)
      WU_IDLE: if (start) state_next = (req.d == '0) ? WU_DONE : WU_MUL;
      WU_MUL:  if (cnt[1:0] == 2'd3) state_next = WU_CHK;
      WU_CHK:  state_next = sat ? WU_DONE : WU_DIV;
      WU_DIV:  if (cnt == WCNT_BITS'(WEIGHT_BITS - 1)) state_next = WU_DONE;
      WU_DONE: state_next = WU_IDLE;
      default: state_next = WU_IDLE;
    endcase
  end

  always_comb begin
    done = (state == WU_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= WU_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      WU_IDLE: begin
        a_r    <= req.a;
        c_r    <= req.c;
        d_r    <= req.d;
        acc    <= '0;
        cnt    <= '0;
        weight <= '1;
      end
      WU_MUL: begin
        acc <= acc + prod_sh;
        cnt <= (cnt[1:0] == 2'd3) ? '0 : cnt + 1'b1;
      end
      WU_CHK: begin
        rem    <= D_BITS'(top);
        weight <= sat ? '1 : '0;
      end
      WU_DIV: begin
        rem    <= qbit ? D_BITS'(trial - {1'b0, d_r}) : trial[D_BITS-1:0];
        weight <= {weight[WEIGHT_BITS-2:0], qbit};
        acc    <= acc << 1;
        cnt    <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### hdl/lda_gibbs_topic_sampler_top.sv
`timescale 1ns / 1ps
// Collapsed Gibbs topic sampler for LDA. A sample item (func 0) removes the
// token's old topic, when it is in use, from the word-topic, doc-topic and
// topic-total counts, forms each topic's Q16 weight
// (wt+beta)(dt+alpha)/(total+V*beta) in a shared multiply/divide unit,
// stores the running sum, scales the random draw by the final sum and scans
// for the first topic that reaches it, then adds the new topic back. One
// item at a time: in_ready is high only while idle. Each topic's weight
// takes the weight unit's 4 partial products plus 42 divide steps unless it
// saturates, and the scan reads and compares the sum memory for each topic
// it passes. A finished result sits in the output register, so the next
// item can be accepted while it waits. Configuration must be written only
// while idle; the block itself does not enforce it. Count tables have no
// reset; topic deltas reset to zero.
`include "lda_gibbs_topic_sampler_top_defines.svh"
module lda_gibbs_topic_sampler_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lgts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lgts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lgts_pkg::FUNC_BITS-1:0]      func,
  input  logic [lgts_pkg::DOC_BITS-1:0]       doc,
  input  logic [lgts_pkg::WORD_BITS-1:0]      word,
  input  logic [lgts_pkg::TOPIC_BITS-1:0]     topic,
  input  logic [lgts_pkg::DATA_BITS-1:0]      value,
  input  logic [lgts_pkg::DATA_BITS-1:0]      random,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lgts_pkg::TOPIC_BITS-1:0]     new_topic,
  output logic [lgts_pkg::DATA_BITS-1:0]      read_value,
  output logic signed [lgts_pkg::DATA_BITS-1:0] topic_change
);
  import lgts_pkg::*;

  localparam int WT_DEPTH = WORD_DEPTH * MAX_TOPICS;
  localparam int DT_DEPTH = DOC_DEPTH * MAX_TOPICS;

  state_t state, state_next;

  // configuration
  logic [PRIOR_BITS-1:0] alpha_q16, beta_q16, vocab_size;
  logic [NT_BITS-1:0]    num_topics;
  logic [VB_BITS-1:0]    vbeta;
  logic [TOPIC_BITS-1:0] k_last;

  // latched item
  func_t                 func_r;
  logic [DOC_BITS-1:0]   doc_r;
  logic [WORD_BITS-1:0]  word_r;
  logic [TOPIC_BITS-1:0] topic_r;
  logic [DATA_BITS-1:0]  value_r, random_r;

  // sequencing
  logic [TOPIC_BITS-1:0] k, nt, sel;
  logic [CUM_BITS-1:0]   sum, sum_next;
  logic [CUM_BITS:0]     sum_add;
  logic [PHI_BITS-1:0]   p_hi;
  logic [2*DATA_BITS-1:0] p_lo;
  logic [U_BITS-1:0]     u;
  logic                  hit, out_free;

  // count stores
  logic [COUNT_BITS-1:0] wt_mem [WT_DEPTH];
  logic [COUNT_BITS-1:0] dt_mem [DT_DEPTH];
  logic [TOTAL_BITS-1:0] tt_mem [MAX_TOPICS];
  logic [COUNT_BITS-1:0] dl_mem [DOC_DEPTH];
  logic [DATA_BITS-1:0]  td_mem [MAX_TOPICS];
  logic [MAX_TOPICS-1:0] td_valid;
  logic [CUM_BITS-1:0]   cw_mem [MAX_TOPICS];

  logic [COUNT_BITS-1:0] wt_rd, dt_rd;
  logic [TOTAL_BITS-1:0] tt_rd;
  logic [DATA_BITS-1:0]  td_rd, td_cur;
  logic                  td_ok;
  logic [CUM_BITS-1:0]   cw_rd;

  logic                  wt_we, dt_we, tt_we, td_we, dl_we;
  logic [COUNT_BITS-1:0] wt_wdata, dt_wdata;
  logic [TOTAL_BITS-1:0] tt_wdata;
  logic [DATA_BITS-1:0]  td_wdata;

  // weight unit
  wu_req_t                wu_req;
  logic                   wu_start, wu_done;
  logic [WEIGHT_BITS-1:0] wu_weight;

  lgts_weight_unit u_weight (
    .clk    (clk),
    .rst    (rst),
    .start  (wu_start),
    .req    (wu_req),
    .done   (wu_done),
    .weight (wu_weight)
  );

  // effective topic count is num_topics clamped to 1..MAX_TOPICS
  always_comb begin
    if (num_topics == '0)                           k_last = '0;
    else if (num_topics > NT_BITS'(MAX_TOPICS))     k_last = TOPIC_BITS'(MAX_TOPICS - 1);
    else                                            k_last = TOPIC_BITS'(num_topics - 1'b1);
  end

  always_comb begin
    td_cur   = td_ok ? td_rd : '0;
    sum_add  = {1'b0, sum} + (CUM_BITS + 1)'(wu_weight);
    sum_next = sum_add[CUM_BITS] ? '1 : sum_add[CUM_BITS-1:0];
    hit      = ({1'b0, cw_rd} >= u) || (k == k_last);
    out_free = !out_valid || out_ready;
    wu_req.a = (A_BITS'(wt_rd) << FRAC_BITS) + A_BITS'(beta_q16);
    wu_req.c = (A_BITS'(dt_rd) << FRAC_BITS) + A_BITS'(alpha_q16);
    wu_req.d = (D_BITS'(tt_rd) << FRAC_BITS) + D_BITS'(vbeta);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        case (func_r)
          FUNC_SAMPLE: state_next = (topic_r <= k_last) ? ST_DEC_WR : ST_W_RD;
          FUNC_LOAD_WT, FUNC_LOAD_DT, FUNC_LOAD_TT, FUNC_LOAD_DL:
            state_next = ST_IDLE;
          default: state_next = ST_OUT;
        endcase
      end
      ST_DEC_WR: state_next = ST_W_RD;
      ST_W_RD:   state_next = ST_W_LD;
      ST_W_LD:   state_next = ST_W_RUN;
      ST_W_RUN:  if (wu_done) state_next = (k == k_last) ? ST_PICK1 : ST_W_RD;
      ST_PICK1:  state_next = ST_PICK2;
      ST_PICK2:  state_next = ST_S_RD;
      ST_S_RD:   state_next = ST_S_CMP;
      ST_S_CMP:  state_next = hit ? ST_INC_RD : ST_S_RD;
      ST_INC_RD: state_next = ST_INC_WR;
      ST_INC_WR: state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    wu_start = (state == ST_W_LD);
    case (state)
      ST_W_RD, ST_W_LD, ST_W_RUN: sel = k;
      ST_INC_RD, ST_INC_WR:       sel = nt;
      default:                    sel = topic_r;
    endcase
    wt_we = 1'b0; dt_we = 1'b0; tt_we = 1'b0; td_we = 1'b0; dl_we = 1'b0;
    wt_wdata = value_r[COUNT_BITS-1:0];
    dt_wdata = value_r[COUNT_BITS-1:0];
    tt_wdata = value_r;
    td_wdata = td_cur;
    case (state)
      ST_EXEC: begin
        wt_we = (func_r == FUNC_LOAD_WT);
        dt_we = (func_r == FUNC_LOAD_DT);
        tt_we = (func_r == FUNC_LOAD_TT);
        dl_we = (func_r == FUNC_LOAD_DL);
      end
      ST_DEC_WR: begin
        // decrements saturate at zero; delta moves only with the total
        wt_we    = 1'b1;
        dt_we    = 1'b1;
        wt_wdata = (wt_rd == '0) ? '0 : wt_rd - 1'b1;
        dt_wdata = (dt_rd == '0) ? '0 : dt_rd - 1'b1;
        tt_we    = (tt_rd != '0);
        td_we    = (tt_rd != '0);
        tt_wdata = tt_rd - 1'b1;
        td_wdata = td_cur - 1'b1;
      end
      ST_INC_WR: begin
        wt_we    = 1'b1;
        dt_we    = 1'b1;
        wt_wdata = (wt_rd == '1) ? wt_rd : wt_rd + 1'b1;
        dt_wdata = (dt_rd == '1) ? dt_rd : dt_rd + 1'b1;
        tt_we    = (tt_rd != '1);
        td_we    = (tt_rd != '1);
        tt_wdata = tt_rd + 1'b1;
        td_wdata = td_cur + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q16  <= PRIOR_BITS'(6554);
      beta_q16   <= PRIOR_BITS'(655);
      num_topics <= NT_BITS'(64);
      vocab_size <= PRIOR_BITS'(4096);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ALPHA: alpha_q16  <= cfg_data;
        CFG_BETA:  beta_q16   <= cfg_data;
        CFG_NT:    num_topics <= cfg_data[NT_BITS-1:0];
        CFG_VOCAB: vocab_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // V*beta tracks the registers; settled long before it is used
  always_ff @(posedge clk) begin
    vbeta <= vocab_size * beta_q16;
  end

  // item capture and sampling datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      func_r   <= func_t'(func);
      doc_r    <= doc;
      word_r   <= word;
      topic_r  <= topic;
      value_r  <= value;
      random_r <= random;
    end
    case (state)
      ST_EXEC: begin
        k   <= '0;
        sum <= '0;
        nt  <= '0;
      end
      ST_W_RUN: if (wu_done) begin
        sum <= sum_next;
        if (k != k_last) k <= k + 1'b1;
      end
      ST_PICK1: begin
        p_hi <= random_r * sum[CUM_BITS-1:32];
        p_lo <= random_r * sum[31:0];
      end
      ST_PICK2: begin
        u <= U_BITS'(p_hi) + U_BITS'(p_lo[2*DATA_BITS-1:32]);
        k <= '0;
      end
      ST_S_CMP: begin
        if (hit) nt <= k;
        else     k  <= k + 1'b1;
      end
      default: ;
    endcase
  end

  // count memories: one write each; all but the doc lengths have one registered read
  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[{word_r, sel}] <= wt_wdata;
    if (dt_we) dt_mem[{doc_r, sel}]  <= dt_wdata;
    if (tt_we) tt_mem[sel]           <= tt_wdata;
    if (td_we) td_mem[sel]           <= td_wdata;
    if (dl_we) dl_mem[doc_r]         <= value_r[COUNT_BITS-1:0];
    if (state == ST_W_RUN && wu_done) cw_mem[k] <= sum_next;
    wt_rd <= wt_mem[{word_r, sel}];
    dt_rd <= dt_mem[{doc_r, sel}];
    tt_rd <= tt_mem[sel];
    td_rd <= td_mem[sel];
    td_ok <= td_valid[sel];
    cw_rd <= cw_mem[k];
  end

  // delta entries read as zero until first written
  always_ff @(posedge clk) begin
    if (rst)        td_valid      <= '0;
    else if (td_we) td_valid[sel] <= 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      new_topic    <= '0;
      read_value   <= '0;
      topic_change <= '0;
      case (func_r)
        FUNC_SAMPLE:  new_topic    <= nt;
        FUNC_READ_WT: read_value   <= DATA_BITS'(wt_rd);
        FUNC_READ_DT: read_value   <= DATA_BITS'(dt_rd);
        FUNC_READ_TT: begin
          read_value   <= tt_rd;
          topic_change <= td_cur;
        end
        default: ;
      endcase
    end
  end

  `LGTS_ASSERT(a_accept_leaves_idle, clk, rst, (in_valid && in_ready) |=> (state != ST_IDLE))
  `LGTS_ASSERT(a_pick_in_range, clk, rst, (state == ST_OUT && func_r == FUNC_SAMPLE) |-> (nt <= k_last))
  `LGTS_ASSERT(a_scan_in_range, clk, rst, (state == ST_S_CMP) |-> (k <= k_last))
  `LGTS_ASSERT(a_start_waits, clk, rst, wu_start |=> (state == ST_W_RUN))

endmodule

### dv/lda_gibbs_topic_sampler_checker.sv
`timescale 1ns / 1ps
module lda_gibbs_topic_sampler_checker
  import lgts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [FUNC_BITS-1:0]      func,
  input  logic [DOC_BITS-1:0]       doc,
  input  logic [WORD_BITS-1:0]      word,
  input  logic [TOPIC_BITS-1:0]     topic,
  input  logic [DATA_BITS-1:0]      value,
  input  logic [DATA_BITS-1:0]      random,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [TOPIC_BITS-1:0]     new_topic,
  input  logic [DATA_BITS-1:0]      read_value,
  input  logic signed [DATA_BITS-1:0] topic_change,
  output int                        pending,
  output int                        errors,
  output int                        samples_seen,
  output int                        reads_seen
);

  localparam logic [63:0] WMAX = (64'd1 << WEIGHT_BITS) - 1;
  localparam logic [63:0] SUM_MAX = (64'd1 << CUM_BITS) - 1;
  localparam logic [31:0] CNT_MAX = (32'd1 << COUNT_BITS) - 1;

  typedef struct {
    logic [TOPIC_BITS-1:0] nt;
    logic [DATA_BITS-1:0]  rv;
    logic [DATA_BITS-1:0]  tc;
  } sampler_result_t;

  logic [PRIOR_BITS-1:0] alpha, beta, vocab;
  logic [NT_BITS-1:0]    ntopics;
  logic [COUNT_BITS-1:0] wt_cnt [int];
  logic [COUNT_BITS-1:0] dt_cnt [int];
  logic [31:0]           totals [MAX_TOPICS];
  logic [31:0]           deltas [MAX_TOPICS];
  logic [CUM_BITS-1:0]   cum_sum [MAX_TOPICS];
  sampler_result_t       expected_results [$];

  function automatic void queue_result(sampler_result_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic logic [63:0] topic_weight(logic [63:0] a, logic [63:0] c, logic [63:0] d);
    logic [127:0] q;
    if (d == 0) return WMAX;
    q = (128'(a) * 128'(c)) / 128'(d);
    if (q > 128'(WMAX)) return WMAX;
    return q[63:0];
  endfunction

  function automatic logic [63:0] wt_get(int key);
    return wt_cnt.exists(key) ? 64'(wt_cnt[key]) : 64'd0;
  endfunction

  function automatic logic [63:0] dt_get(int key);
    return dt_cnt.exists(key) ? 64'(dt_cnt[key]) : 64'd0;
  endfunction

  // Removes the old topic, builds the cumulative weights, picks, adds back.
  function automatic logic [TOPIC_BITS-1:0] resample_token(int d, int w, int old,
                                                          logic [31:0] rnd);
    int k_eff, pick, wk, dk;
    logic [63:0] vbeta, sum, u, a, c, den;
    k_eff = ntopics;
    if (k_eff < 1) k_eff = 1;
    if (k_eff > MAX_TOPICS) k_eff = MAX_TOPICS;
    vbeta = 64'(vocab) * 64'(beta);
    if (old < k_eff) begin
      wk = w * MAX_TOPICS + old;
      dk = d * MAX_TOPICS + old;
      if (wt_get(wk) > 0) wt_cnt[wk] = wt_cnt[wk] - 1'b1;
      if (dt_get(dk) > 0) dt_cnt[dk] = dt_cnt[dk] - 1'b1;
      if (totals[old] > 0) begin
        totals[old]--;
        deltas[old]--;
      end
    end
    sum = 0;
    for (int k = 0; k < k_eff; k++) begin
      a = (wt_get(w * MAX_TOPICS + k) << FRAC_BITS) + 64'(beta);
      c = (dt_get(d * MAX_TOPICS + k) << FRAC_BITS) + 64'(alpha);
      den = (64'(totals[k]) << FRAC_BITS) + vbeta;
      sum += topic_weight(a, c, den);
      if (sum > SUM_MAX) sum = SUM_MAX;
      cum_sum[k] = sum[CUM_BITS-1:0];
    end
    u = 64'(rnd) * (sum >> 32) + ((64'(rnd) * (sum & 64'hFFFF_FFFF)) >> 32);
    pick = k_eff - 1;
    for (int k = 0; k < k_eff; k++) begin
      if (64'(cum_sum[k]) >= u) begin
        pick = k;
        break;
      end
    end
    wk = w * MAX_TOPICS + pick;
    dk = d * MAX_TOPICS + pick;
    if (wt_get(wk) < CNT_MAX) wt_cnt[wk] = COUNT_BITS'(wt_get(wk) + 1);
    if (dt_get(dk) < CNT_MAX) dt_cnt[dk] = COUNT_BITS'(dt_get(dk) + 1);
    if (totals[pick] != 32'hFFFF_FFFF) begin
      totals[pick]++;
      deltas[pick]++;
    end
    return TOPIC_BITS'(pick);
  endfunction

  always @(posedge clk) begin
    sampler_result_t r, exp_r;
    if (rst) begin
      alpha = 24'd6554;
      beta = 24'd655;
      ntopics = 7'd64;
      vocab = 24'd4096;
      foreach (deltas[k]) deltas[k] = 0;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ALPHA: alpha = cfg_data;
          CFG_BETA:  beta = cfg_data;
          CFG_NT:    ntopics = cfg_data[NT_BITS-1:0];
          CFG_VOCAB: vocab = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: new_topic %0d read_value %0h",
                 new_topic, read_value);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (new_topic !== exp_r.nt) begin
            $error("new_topic expected %0d actual %0d", exp_r.nt, new_topic);
            errors++;
          end
          if (read_value !== exp_r.rv) begin
            $error("read_value expected %0h actual %0h", exp_r.rv, read_value);
            errors++;
          end
          if (topic_change !== exp_r.tc) begin
            $error("topic_change expected %0d actual %0d",
                   $signed(exp_r.tc), topic_change);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        r.nt = 0;
        r.rv = 0;
        r.tc = 0;
        case (func_t'(func))
          FUNC_SAMPLE: begin
            r.nt = resample_token(doc, word, topic, random);
            queue_result(r);
            samples_seen++;
          end
          FUNC_LOAD_WT: wt_cnt[word * MAX_TOPICS + topic] = value[COUNT_BITS-1:0];
          FUNC_LOAD_DT: dt_cnt[doc * MAX_TOPICS + topic] = value[COUNT_BITS-1:0];
          FUNC_LOAD_TT: totals[topic] = value;
          FUNC_LOAD_DL: ;  // doc length is stored but never read back
          FUNC_READ_WT: begin
            r.rv = 32'(wt_get(word * MAX_TOPICS + topic));
            queue_result(r);
            reads_seen++;
          end
          FUNC_READ_DT: begin
            r.rv = 32'(dt_get(doc * MAX_TOPICS + topic));
            queue_result(r);
            reads_seen++;
          end
          default: begin
            r.rv = totals[topic];
            r.tc = deltas[topic];
            queue_result(r);
            reads_seen++;
          end
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

### dv/lda_gibbs_topic_sampler_top_tb.sv
`timescale 1ns / 1ps
module lda_gibbs_topic_sampler_top_tb;
  import lgts_pkg::*;

  logic                      clk, rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid, in_ready;
  logic [FUNC_BITS-1:0]      func;
  logic [DOC_BITS-1:0]       doc;
  logic [WORD_BITS-1:0]      word;
  logic [TOPIC_BITS-1:0]     topic;
  logic [DATA_BITS-1:0]      value, random;
  logic                      out_valid, out_ready;
  logic [TOPIC_BITS-1:0]     new_topic;
  logic [DATA_BITS-1:0]      read_value;
  logic signed [DATA_BITS-1:0] topic_change;

  int pending, errors, samples_seen, reads_seen;

  // Sample tokens only touch these words and docs; every topic of them is
  // loaded first, so no sample ever reads a count that was never written.
  logic [WORD_BITS-1:0] word_pool [3];
  logic [DOC_BITS-1:0]  doc_pool [3];

  bit calm;          // no idling on either side
  bit hold_req;      // ask the receiver for one long hold-off
  int hold_left;

  lda_gibbs_topic_sampler_top dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .doc(doc), .word(word), .topic(topic),
    .value(value), .random(random),
    .out_valid(out_valid), .out_ready(out_ready),
    .new_topic(new_topic), .read_value(read_value), .topic_change(topic_change)
  );

  lda_gibbs_topic_sampler_checker chk (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .doc(doc), .word(word), .topic(topic),
    .value(value), .random(random),
    .out_valid(out_valid), .out_ready(out_ready),
    .new_topic(new_topic), .read_value(read_value), .topic_change(topic_change),
    .pending(pending), .errors(errors),
    .samples_seen(samples_seen), .reads_seen(reads_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off on request
  // so the output register fills and the input side backs up.
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
        out_ready <= 0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 11);
      end
    end
  end

  // Hand one item over; returns at the edge where it was taken.
  task automatic send_item(func_t f, logic [DOC_BITS-1:0] d, logic [WORD_BITS-1:0] w,
                           logic [TOPIC_BITS-1:0] t, logic [31:0] v, logic [31:0] r);
    if (!calm && $urandom_range(99) < 11) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    doc <= d;
    word <= w;
    topic <= t;
    value <= v;
    random <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Stop offering and let every result drain; loads leave no result, so a
  // wait after the last result covers a load still in flight.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_config(logic [23:0] a, logic [23:0] b, logic [23:0] k, logic [23:0] v);
    drain();
    write_reg(CFG_ALPHA, a);
    write_reg(CFG_BETA, b);
    write_reg(CFG_NT, k);
    write_reg(CFG_VOCAB, v);
    cfg_write <= 0;
  endtask

  // Counts: mostly small, sometimes zero or the full width.
  function automatic logic [31:0] rand_count();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 0;
    if (sel < 18) return 32'h00FF_FFFF;
    if (sel < 28) return $urandom;
    return $urandom_range(0, 40);
  endfunction

  task automatic random_item();
    int sel;
    logic [WORD_BITS-1:0] w;
    logic [DOC_BITS-1:0]  d;
    w = word_pool[$urandom_range(2)];
    d = doc_pool[$urandom_range(2)];
    sel = $urandom_range(99);
    if (sel < 50)
      send_item(FUNC_SAMPLE, d, w, TOPIC_BITS'($urandom), 0, $urandom);
    else if (sel < 58)
      send_item(FUNC_LOAD_WT, 0, ($urandom_range(3) == 0) ? WORD_BITS'($urandom) : w,
                TOPIC_BITS'($urandom), rand_count(), $urandom);
    else if (sel < 66)
      send_item(FUNC_LOAD_DT, ($urandom_range(3) == 0) ? DOC_BITS'($urandom) : d, 0,
                TOPIC_BITS'($urandom), rand_count(), $urandom);
    else if (sel < 71)
      send_item(FUNC_LOAD_TT, 0, 0, TOPIC_BITS'($urandom),
                ($urandom_range(4) == 0) ? 32'hFFFF_FFFF : rand_count(), 0);
    else if (sel < 75)
      send_item(FUNC_LOAD_DL, DOC_BITS'($urandom), WORD_BITS'($urandom),
                TOPIC_BITS'($urandom), $urandom, $urandom);
    else if (sel < 83)
      send_item(FUNC_READ_WT, DOC_BITS'($urandom), w, TOPIC_BITS'($urandom),
                $urandom, $urandom);
    else if (sel < 91)
      send_item(FUNC_READ_DT, d, WORD_BITS'($urandom), TOPIC_BITS'($urandom),
                $urandom, $urandom);
    else
      send_item(FUNC_READ_TT, DOC_BITS'($urandom), WORD_BITS'($urandom),
                TOPIC_BITS'($urandom), $urandom, $urandom);
  endtask

  initial begin
    rst = 1;
    cfg_write = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_valid = 0;
    func = 0;
    doc = 0;
    word = 0;
    topic = 0;
    value = 0;
    random = 0;
    calm = 1;
    hold_req = 0;
    hold_left = 0;
    word_pool = '{12'd0, 12'hFFF, WORD_BITS'($urandom)};
    doc_pool = '{10'd0, 10'h3FF, DOC_BITS'($urandom)};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Preload: word 0 and doc 0 stay all zero (zero weights with alpha 0),
    // the others get mixed counts; topic 0 total starts at zero.
    for (int t = 0; t < MAX_TOPICS; t++) begin
      for (int i = 0; i < 3; i++) begin
        send_item(FUNC_LOAD_WT, 0, word_pool[i], TOPIC_BITS'(t),
                  (i == 0) ? 0 : rand_count(), 0);
        send_item(FUNC_LOAD_DT, doc_pool[i], 0, TOPIC_BITS'(t),
                  (i == 0) ? 0 : rand_count(), 0);
      end
      send_item(FUNC_LOAD_TT, 0, 0, TOPIC_BITS'(t), (t == 0) ? 0 : $urandom_range(0, 5000), 0);
    end

    // Directed: extremes at reset config (64 topics), saturation, reads.
    send_item(FUNC_SAMPLE, 0, 0, 0, 0, 32'h0);
    send_item(FUNC_SAMPLE, 10'h3FF, 12'hFFF, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_LOAD_WT, 0, word_pool[1], 5, 32'hFFFF_FFFF, 0);
    send_item(FUNC_LOAD_TT, 0, 0, 6'h3F, 32'hFFFF_FFFF, 0);
    send_item(FUNC_SAMPLE, doc_pool[1], word_pool[1], 5, 0, 32'h8000_0000);
    send_item(FUNC_READ_WT, 0, word_pool[1], 5, 0, 0);
    send_item(FUNC_READ_DT, doc_pool[1], 0, 5, 0, 0);
    send_item(FUNC_READ_TT, 0, 0, 0, 0, 0);
    send_item(FUNC_READ_TT, 0, 0, 6'h3F, 0, 0);
    send_item(FUNC_LOAD_DL, 10'h3FF, 0, 0, 32'hFFFF_FFFF, 0);
    send_item(FUNC_LOAD_DL, 0, 0, 0, 0, 0);
    // a few tokens pass before the checks at small topic counts
    set_config(24'd6554, 24'd655, 24'd4, 24'd4096);
    send_item(FUNC_SAMPLE, doc_pool[2], word_pool[2], 6'd40, 0, $urandom);  // old topic not in use
    send_item(FUNC_SAMPLE, 0, 0, 6'd1, 0, 32'hFFFF_FFFF);                   // counts already zero
    send_item(FUNC_READ_TT, 0, 0, 1, 0, 0);

    // Random phases across the register ranges.
    calm = 0;
    for (int i = 0; i < 40; i++) random_item();
    set_config(24'd1, 24'd1, 24'd2, 24'd1);
    hold_req = 1;      // long output stall while items keep coming
    for (int i = 0; i < 50; i++) random_item();
    set_config(24'hFF_FFFF, 24'hFF_FFFF, 24'd8, 24'hFF_FFFF);
    for (int i = 0; i < 40; i++) random_item();
    // zero priors: zero denominators and all-zero sums
    set_config(24'd0, 24'd0, 24'd3, 24'd0);
    send_item(FUNC_SAMPLE, 0, 0, 0, 0, $urandom);
    for (int i = 0; i < 40; i++) random_item();
    // topic count field 0 clamps to one topic
    set_config(24'($urandom_range(1, 100000)), 24'($urandom_range(1, 5000)), 24'd0,
               24'($urandom_range(1, 100000)));
    for (int i = 0; i < 30; i++) random_item();
    set_config(24'd6554, 24'd655, 24'd1, 24'd4096);
    calm = 1;          // stretch with no idling at all
    for (int i = 0; i < 40; i++) random_item();
    calm = 0;
    // 7-bit field above the table size clamps to 64 topics; slow, so short
    set_config(24'h00_FFFF, 24'd300, 24'd127, 24'd50000);
    for (int i = 0; i < 15; i++) random_item();
    set_config(24'd6554, 24'd655, 24'd64, 24'd4096);
    for (int i = 0; i < 15; i++) random_item();
    set_config(24'($urandom), 24'($urandom), 24'd5, 24'($urandom));
    for (int i = 0; i < 40; i++) random_item();

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d sampled tokens and %0d table reads over ten register settings",
             samples_seen, reads_seen);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #30ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
